/* hw/rtl/assert_macros.svh */
// assertion macros used by the decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/fpd_pkg.sv */
// types and constants of the framed packet decoder
package fpd_pkg;

  // parser phases
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_CHECK = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_END   = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_TEXT     = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
  localparam logic [2:0] KIND_OK       = 3'd2;
  localparam logic [2:0] KIND_MISMATCH = 3'd3;
  localparam logic [2:0] KIND_NO_END   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_END_MARKER  = 2'd2;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hC0;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hFE;
  localparam logic [7:0] END_MARKER_RST  = 8'hED;

  localparam logic [7:0] SEED_LOW  = 8'h12;
  localparam logic [7:0] SEED_HIGH = 8'h34;
  localparam logic [8:0] MODULUS   = 9'd255;

  localparam logic [7:0] RX_CHECK0_RST = 8'd1;
  localparam logic [7:0] RX_CHECK1_RST = 8'd2;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] end_marker;
  } fpd_cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] held_byte;
    logic [7:0] older_byte;
    logic [1:0] fill_count;
    logic [7:0] cmd_reg;
    logic [7:0] len_reg;
    logic [7:0] position;
    logic [7:0] rx_check0;
    logic [7:0] rx_check1;
    logic [7:0] sum_low;
    logic [7:0] sum_high;
  } fpd_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] cmd_code;
    logic [7:0] pay_length;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
  } fpd_result_t;

endpackage

/* hw/rtl/framed_packet_decoder_core.sv */
// framed packet decoder top level: input register, parser step, result register
// a result reaches the outputs through the input register, then the result register
// throughput: one byte per cycle from the combinational parser step; a stalled result
//   register holds the input register, so input stalls follow output stalls at once
// reset: asynchronous, active low; parser hunts for sync, sums at their seeds,
//   sync pattern c0 fe and end marker ed, both registers empty
`include "assert_macros.svh"

module framed_packet_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  // received byte channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] cmd_code_o,
  output logic [7:0] pay_length_o,
  output logic [7:0] byte_index_o,
  output logic [7:0] byte_value_o
);
  import fpd_pkg::*;

  fpd_cfg_t    cfg;
  fpd_state_t  state_q, state_d;
  fpd_result_t res_d, res_q;
  logic        res_valid_d;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  logic        advance;

  // registered sync pattern and end marker
  fpd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the byte in the input register moves on when the result slot is free or
  // being emptied this cycle; a byte with no result still waits for the slot
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // parser step on the registered byte
  fpd_step u_step (
    .cfg_i       (cfg),
    .cur_i       (state_q),
    .byte_i      (in_byte_q),
    .nxt_o       (state_d),
    .res_valid_o (res_valid_d),
    .res_o       (res_d)
  );

  // parser state, updated once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= PH_HUNT;
      state_q.held_byte  <= '0;
      state_q.older_byte <= '0;
      state_q.fill_count <= '0;
      state_q.cmd_reg    <= '0;
      state_q.len_reg    <= '0;
      state_q.position   <= '0;
      state_q.rx_check0  <= RX_CHECK0_RST;
      state_q.rx_check1  <= RX_CHECK1_RST;
      state_q.sum_low    <= SEED_LOW;
      state_q.sum_high   <= SEED_HIGH;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid_d) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = res_q.kind;
  assign cmd_code_o   = res_q.cmd_code;
  assign pay_length_o = res_q.pay_length;
  assign byte_index_o = res_q.byte_index;
  assign byte_value_o = res_q.byte_value;

  // a byte taken at the end marker always leaves a status item behind
  `ASSERT_PROP(a_end_gives_status, clk_i, rst_ni,
               (advance && state_q.phase == PH_END) |=> out_valid_q)
  // payload phase only continues or moves to the end marker
  `ASSERT_PROP(a_data_exit, clk_i, rst_ni,
               (advance && state_q.phase == PH_DATA) |=>
               (state_q.phase == PH_DATA || state_q.phase == PH_END))
  // hunt fill count saturates at two
  `ASSERT_NEVER(a_fill_range, clk_i, rst_ni, state_q.fill_count == 2'd3)
  // result kinds stay within the defined codes
  `ASSERT_NEVER(a_kind_range, clk_i, rst_ni, out_valid_q && res_q.kind > KIND_NO_END)

endmodule

/* hw/rtl/fpd_cfg_regs.sv */
// configuration registers: sync pattern and end marker
module fpd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  output fpd_pkg::fpd_cfg_t cfg_o
);
  import fpd_pkg::*;

  fpd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
      cfg_q.end_marker  <= END_MARKER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data_i;
        REG_SYNC_SECOND: cfg_q.sync_second <= cfg_data_i;
        REG_END_MARKER:  cfg_q.end_marker  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/fpd_step.sv */
// per-byte parser step: next state and optional result
module fpd_step (
  input  fpd_pkg::fpd_cfg_t    cfg_i,
  input  fpd_pkg::fpd_state_t  cur_i,
  input  logic [7:0]           byte_i,
  output fpd_pkg::fpd_state_t  nxt_o,
  output logic                 res_valid_o,
  output fpd_pkg::fpd_result_t res_o
);
  import fpd_pkg::*;

  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MODULUS) s = s - MODULUS;
    return s[7:0];
  endfunction

  logic [7:0] lo_base, hi_base, lo_new, hi_new;
  logic [8:0] pos_inc;

  // one shared fletcher step; command phase restarts from the seeds
  assign lo_base = (cur_i.phase == PH_CMD) ? SEED_LOW  : cur_i.sum_low;
  assign hi_base = (cur_i.phase == PH_CMD) ? SEED_HIGH : cur_i.sum_high;
  assign lo_new  = add_mod255(lo_base, byte_i);
  assign hi_new  = add_mod255(hi_base, lo_new);
  assign pos_inc = {1'b0, cur_i.position} + 9'd1;

  always_comb begin
    nxt_o       = cur_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (cur_i.phase)
      PH_HUNT: begin
        if (cur_i.fill_count < 2'd2) begin
          nxt_o.fill_count = cur_i.fill_count + 2'd1;
        end else begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_TEXT;
          res_o.byte_value = cur_i.older_byte;
        end
        nxt_o.older_byte = cur_i.held_byte;
        nxt_o.held_byte  = byte_i;
        if (cur_i.held_byte == cfg_i.sync_first && byte_i == cfg_i.sync_second) begin
          nxt_o.phase = PH_CMD;
        end
      end
      PH_CMD: begin
        nxt_o.cmd_reg  = byte_i;
        nxt_o.sum_low  = lo_new;
        nxt_o.sum_high = hi_new;
        nxt_o.phase    = PH_LEN;
      end
      PH_LEN: begin
        nxt_o.len_reg  = byte_i;
        nxt_o.position = '0;
        nxt_o.sum_low  = lo_new;
        nxt_o.sum_high = hi_new;
        nxt_o.phase    = PH_CHECK;
      end
      PH_CHECK: begin
        if (cur_i.position[0]) begin
          nxt_o.rx_check1 = byte_i;
          nxt_o.position  = '0;
          nxt_o.phase     = PH_DATA;
        end else begin
          nxt_o.rx_check0 = byte_i;
          nxt_o.position  = pos_inc[7:0];
        end
      end
      PH_DATA: begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_PAYLOAD;
        res_o.cmd_code   = cur_i.cmd_reg;
        res_o.pay_length = cur_i.len_reg;
        res_o.byte_index = cur_i.position;
        res_o.byte_value = byte_i;
        nxt_o.sum_low    = lo_new;
        nxt_o.sum_high   = hi_new;
        nxt_o.position   = pos_inc[7:0];
        // zero length still takes one payload byte
        if (pos_inc >= {1'b0, cur_i.len_reg}) nxt_o.phase = PH_END;
      end
      PH_END: begin
        res_valid_o      = 1'b1;
        res_o.cmd_code   = cur_i.cmd_reg;
        res_o.pay_length = cur_i.len_reg;
        res_o.byte_index = cur_i.position;
        if (byte_i != cfg_i.end_marker) begin
          res_o.kind = KIND_NO_END;
        end else if (cur_i.rx_check0 == cur_i.sum_low &&
                     cur_i.rx_check1 == cur_i.sum_high) begin
          res_o.kind = KIND_OK;
        end else begin
          res_o.kind = KIND_MISMATCH;
        end
        nxt_o.phase      = PH_HUNT;
        nxt_o.fill_count = '0;
        nxt_o.older_byte = '0;
        nxt_o.position   = '0;
        nxt_o.rx_check0  = RX_CHECK0_RST;
        nxt_o.rx_check1  = RX_CHECK1_RST;
      end
      default: begin
        // unused phase: back to hunting, byte dropped
        nxt_o.phase      = PH_HUNT;
        nxt_o.fill_count = '0;
        nxt_o.older_byte = '0;
        nxt_o.position   = '0;
        nxt_o.rx_check0  = RX_CHECK0_RST;
        nxt_o.rx_check1  = RX_CHECK1_RST;
      end
    endcase
  end

endmodule

/* sim/tb_top.sv */
// self-checking testbench of the framed packet decoder core with its own byte-level predictor
`timescale 1ns / 100ps

module tb_top;
  import fpd_pkg::*;

  localparam int SETTLE_CYCLES  = 4;    // room for a byte still inside the pipeline
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 120;  // receiver back-pressure stretch
  localparam int HOLD_STEP      = 250;  // results between long holds
  localparam int CALM_ITEMS     = 120;  // tail of the run with no idling

  typedef enum logic [1:0] {OP_BYTE, OP_CONFIG, OP_PAUSE} stim_op_e;
  typedef enum logic [1:0] {CHK_GOOD, CHK_WRONG, CHK_ALL_ONES} chk_mode_e;

  typedef struct packed {
    stim_op_e   op;
    logic [1:0] idx;
    logic [7:0] data;
  } stim_item_t;

  // clock, reset and dut ports; the driven ones are known from time zero
  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       cfg_we   = 1'b0;
  logic [1:0] cfg_idx  = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte  = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [2:0] kind;
  logic [7:0] cmd_code;
  logic [7:0] pay_length;
  logic [7:0] byte_index;
  logic [7:0] byte_value;

  // pending stimulus and expected decoder output
  stim_item_t  stim_q[$];
  fpd_result_t pending_results[$];

  // predictor state and its copy of the registers
  fpd_state_t m_st;
  fpd_cfg_t   m_cfg;

  // generator's view of the registers, tracked while the queue is filled
  fpd_cfg_t g_cfg;
  int       g_bytes = 0;

  // bookkeeping of the clocked processes, some of it shared between them
  int taken_count   = 0;
  int quiet_cycles  = 0;
  int idle_cycles   = 0;
  int errors        = 0;
  int bytes_in      = 0;
  int cfg_writes    = 0;
  int results_total = 0;
  int kind_seen[8];

  framed_packet_decoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .cmd_code_o  (cmd_code),
    .pay_length_o(pay_length),
    .byte_index_o(byte_index),
    .byte_value_o(byte_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one step of the fletcher pair, sums packed as {high, low}, both mod 255
  function automatic logic [15:0] fletcher_add(input logic [15:0] sums, input logic [7:0] v);
    int lo;
    int hi;
    lo = (int'(sums[7:0]) + int'(v)) % int'(MODULUS);
    hi = (int'(sums[15:8]) + lo) % int'(MODULUS);
    return {hi[7:0], lo[7:0]};
  endfunction

  // held_byte, cmd, len and the sums survive a return to hunting
  function automatic void back_to_hunt();
    m_st.phase      = PH_HUNT;
    m_st.fill_count = '0;
    m_st.older_byte = '0;
    m_st.position   = '0;
    m_st.rx_check0  = RX_CHECK0_RST;
    m_st.rx_check1  = RX_CHECK1_RST;
  endfunction

  // advance the parser by one received byte; returns 1 when an item comes out
  function automatic bit parse_rx_byte(input logic [7:0] b, output fpd_result_t res);
    bit emits;
    res   = '0;
    emits = 1'b0;
    case (m_st.phase)
      PH_HUNT: begin
        // the older held byte leaves as text once two bytes are in
        if (m_st.fill_count < 2'd2) begin
          m_st.fill_count = m_st.fill_count + 2'd1;
        end else begin
          res.kind       = KIND_TEXT;
          res.byte_value = m_st.older_byte;
          emits          = 1'b1;
        end
        m_st.older_byte = m_st.held_byte;
        m_st.held_byte  = b;
        if (m_st.older_byte == m_cfg.sync_first && m_st.held_byte == m_cfg.sync_second)
          m_st.phase = PH_CMD;
      end
      PH_CMD: begin
        m_st.cmd_reg = b;
        m_st.phase   = PH_LEN;
      end
      PH_LEN: begin
        m_st.len_reg  = b;
        m_st.position = '0;
        m_st.phase    = PH_CHECK;
      end
      PH_CHECK: begin
        if (m_st.position[0]) m_st.rx_check1 = b;
        else m_st.rx_check0 = b;
        m_st.position = m_st.position + 8'd1;
        if (m_st.position >= 8'd2) begin
          // sums restart from the seeds, then take command and length
          {m_st.sum_high, m_st.sum_low} =
            fletcher_add(fletcher_add({SEED_HIGH, SEED_LOW}, m_st.cmd_reg), m_st.len_reg);
          m_st.position = '0;
          m_st.phase    = PH_DATA;
        end
      end
      PH_DATA: begin
        // a zero length still takes one payload byte
        if (int'(m_st.position) >= int'(m_st.len_reg) - 1) m_st.phase = PH_END;
        res.kind       = KIND_PAYLOAD;
        res.cmd_code   = m_st.cmd_reg;
        res.pay_length = m_st.len_reg;
        res.byte_index = m_st.position;
        res.byte_value = b;
        emits          = 1'b1;
        {m_st.sum_high, m_st.sum_low} = fletcher_add({m_st.sum_high, m_st.sum_low}, b);
        m_st.position = m_st.position + 8'd1;
      end
      PH_END: begin
        if (b != m_cfg.end_marker)
          res.kind = KIND_NO_END;
        else if (m_st.rx_check0 == m_st.sum_low && m_st.rx_check1 == m_st.sum_high)
          res.kind = KIND_OK;
        else
          res.kind = KIND_MISMATCH;
        res.cmd_code   = m_st.cmd_reg;
        res.pay_length = m_st.len_reg;
        res.byte_index = m_st.position;
        emits          = 1'b1;
        back_to_hunt();
      end
      default: begin
        // unused phase codes drop the byte
        back_to_hunt();
      end
    endcase
    return emits;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  function automatic void queue_byte(input logic [7:0] b);
    stim_item_t it;
    it.op   = OP_BYTE;
    it.idx  = '0;
    it.data = b;
    stim_q.push_back(it);
    g_bytes++;
  endfunction

  function automatic void queue_config(input logic [1:0] idx, input logic [7:0] v);
    stim_item_t it;
    it.op   = OP_CONFIG;
    it.idx  = idx;
    it.data = v;
    stim_q.push_back(it);
    case (idx)
      REG_SYNC_FIRST:  g_cfg.sync_first  = v;
      REG_SYNC_SECOND: g_cfg.sync_second = v;
      REG_END_MARKER:  g_cfg.end_marker  = v;
      default: ;
    endcase
  endfunction

  // one frame; sync_n = 1 relies on the first sync byte still being held
  function automatic void queue_frame(input int sync_n, input logic [7:0] cmd,
                                      input logic [7:0] len, input chk_mode_e chk,
                                      input bit end_ok, input bit extremes);
    logic [7:0]  pay[$];
    logic [15:0] s;
    logic [7:0]  c0;
    logic [7:0]  c1;
    int          n;
    n = (len == 8'd0) ? 1 : int'(len);
    s = fletcher_add(fletcher_add({SEED_HIGH, SEED_LOW}, cmd), len);
    for (int i = 0; i < n; i++) begin
      pay.push_back(extremes ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
      s = fletcher_add(s, pay[i]);
    end
    c0 = s[7:0];
    c1 = s[15:8];
    case (chk)
      CHK_WRONG: begin
        if ($urandom_range(0, 1) == 0) c0 = c0 ^ 8'($urandom_range(1, 255));
        else c1 = c1 ^ 8'($urandom_range(1, 255));
      end
      CHK_ALL_ONES: c1 = 8'hFF;  // sums stay below 255, so never a match
      default: ;
    endcase
    if (sync_n == 2) queue_byte(g_cfg.sync_first);
    queue_byte(g_cfg.sync_second);
    queue_byte(cmd);
    queue_byte(len);
    queue_byte(c0);
    queue_byte(c1);
    foreach (pay[i]) queue_byte(pay[i]);
    queue_byte(end_ok ? g_cfg.end_marker : g_cfg.end_marker ^ 8'($urandom_range(1, 255)));
  endfunction

  // mostly well-formed frames with random content, plus noise, cut frames and pauses
  function automatic void queue_random_traffic(input int nbytes, input bit with_longest);
    stim_item_t it;
    int start_bytes;
    int r;
    int len;
    int n;
    chk_mode_e chk;
    start_bytes = g_bytes;
    if (with_longest)
      queue_frame(2, 8'($urandom_range(0, 255)), 8'd255, CHK_GOOD, 1'b1, 1'b0);
    while (g_bytes - start_bytes < nbytes) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        n   = $urandom_range(0, 99);
        chk = (n < 75) ? CHK_GOOD : (n < 90) ? CHK_WRONG : CHK_ALL_ONES;
        queue_frame(2, 8'($urandom_range(0, 255)), len[7:0], chk,
                    $urandom_range(0, 4) != 0, 1'b0);
      end else if (r < 88) begin
        // line noise, now and then a lone first sync byte
        n = $urandom_range(1, 4);
        repeat (n)
          queue_byte(($urandom_range(0, 3) == 0) ? g_cfg.sync_first
                                                : 8'($urandom_range(0, 255)));
      end else if (r < 96) begin
        // frame cut short, whatever follows is read as its body
        queue_byte(g_cfg.sync_first);
        queue_byte(g_cfg.sync_second);
        n = $urandom_range(0, 4);
        repeat (n) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        // sender waits for every expected item
        it.op   = OP_PAUSE;
        it.idx  = '0;
        it.data = '0;
        stim_q.push_back(it);
      end
    end
  endfunction

  function automatic bit gap_due(input int mode);
    case (mode)
      1:       return $urandom_range(0, 11) == 0;
      2:       return $urandom_range(0, 2) == 0;
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: byte channel and register port, changed on the falling edge
  // ---------------------------------------------------------------------------

  int taken_ack = 0;
  int tx_gap    = 0;
  int tx_mode   = 0;

  always @(negedge clk) begin : sender
    logic       nv;
    logic       nwe;
    logic [7:0] nb;
    logic [7:0] nd;
    logic [1:0] ni;
    stim_item_t head;
    bit         drained;
    bit         calm;
    nv   = in_valid;
    nb   = rx_byte;
    nwe  = 1'b0;
    ni   = cfg_idx;
    nd   = cfg_data;
    calm = stim_q.size() < CALM_ITEMS;
    if (rst_n) begin
      if ($urandom_range(0, 63) == 0) tx_mode = $urandom_range(0, 2);
      // a byte on offer stays put until the decoder takes it
      if (!(in_valid && taken_count == taken_ack)) begin
        nv = 1'b0;
        if (taken_count != taken_ack) begin
          taken_ack = taken_count;
          if (!calm && gap_due(tx_mode)) tx_gap = $urandom_range(1, 10);
        end
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (stim_q.size() > 0) begin
          head    = stim_q[0];
          drained = pending_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES;
          case (head.op)
            OP_BYTE: begin
              nv = 1'b1;
              nb = head.data;
              stim_q.delete(0);
            end
            OP_CONFIG: begin
              // registers only change with the pipeline empty
              if (drained) begin
                nwe = 1'b1;
                ni  = head.idx;
                nd  = head.data;
                stim_q.delete(0);
              end
            end
            default: begin
              if (drained) stim_q.delete(0);
            end
          endcase
        end
      end
    end
    in_valid <= nv;
    rx_byte  <= nb;
    cfg_we   <= nwe;
    cfg_idx  <= ni;
    cfg_data <= nd;
  end

  // ---------------------------------------------------------------------------
  // receiver back-pressure: random bursts plus long holds that fill the decoder
  // ---------------------------------------------------------------------------

  int rx_gap     = 0;
  int rx_mode    = 0;
  int hold_left  = 0;
  int hold_marks = 0;

  always @(negedge clk) begin : receiver
    logic ns;
    bit   calm;
    ns   = 1'b0;
    calm = stim_q.size() < CALM_ITEMS;
    if (rst_n) begin
      if ($urandom_range(0, 63) == 0) rx_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        ns = 1'b1;
        hold_left--;
      end else if (!calm && hold_marks < 2 && results_total >= HOLD_STEP * (hold_marks + 1)) begin
        hold_marks++;
        hold_left = LONG_HOLD - 1;
        ns        = 1'b1;
      end else if (!calm) begin
        if (rx_gap > 0) begin
          ns = 1'b1;
          rx_gap--;
        end else if (gap_due(rx_mode)) begin
          rx_gap = $urandom_range(1, 10) - 1;
          ns     = 1'b1;
        end
      end
    end
    out_stall <= ns;
  end

  // ---------------------------------------------------------------------------
  // monitor: handshakes sampled on the rising edge, prediction and compare
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    fpd_result_t want;
    fpd_result_t got;
    bit          progress;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          REG_SYNC_FIRST:  m_cfg.sync_first  = cfg_data;
          REG_SYNC_SECOND: m_cfg.sync_second = cfg_data;
          REG_END_MARKER:  m_cfg.end_marker  = cfg_data;
          default: ;
        endcase
        cfg_writes++;
        progress = 1'b1;
      end
      if (in_valid && !in_stall) begin
        taken_count++;
        bytes_in++;
        quiet_cycles = 0;
        progress     = 1'b1;
        if (parse_rx_byte(rx_byte, want)) pending_results.push_back(want);
      end else if (quiet_cycles < 1000) begin
        quiet_cycles++;
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        got = {kind, cmd_code, pay_length, byte_index, byte_value};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected item, kind %0d value %0d", $time, got.kind, got.byte_value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", {5'd0, want.kind}, {5'd0, got.kind});
          check_field("cmd_code", want.cmd_code, got.cmd_code);
          check_field("pay_length", want.pay_length, got.pay_length);
          check_field("byte_index", want.byte_index, got.byte_index);
          check_field("byte_value", want.byte_value, got.byte_value);
          kind_seen[want.kind]++;
        end
        results_total++;
      end
      // watchdog on cycles with no handshake at all
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run sequence: fill the queue, release reset, wait for the decoder to drain
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    foreach (kind_seen[i]) kind_seen[i] = 0;

    // predictor starts from the reset state
    m_cfg.sync_first  = SYNC_FIRST_RST;
    m_cfg.sync_second = SYNC_SECOND_RST;
    m_cfg.end_marker  = END_MARKER_RST;
    m_st.held_byte    = '0;
    m_st.cmd_reg      = '0;
    m_st.len_reg      = '0;
    m_st.sum_low      = SEED_LOW;
    m_st.sum_high     = SEED_HIGH;
    back_to_hunt();
    g_cfg = m_cfg;

    // directed part with the reset pattern: byte extremes, then every end status
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h5A);
    queue_frame(2, 8'hFF, 8'd0, CHK_GOOD, 1'b1, 1'b1);      // zero length, one byte read
    queue_frame(2, 8'h00, 8'd2, CHK_ALL_ONES, 1'b1, 1'b1);  // received 255 never matches
    queue_frame(2, 8'h5A, 8'd1, CHK_GOOD, 1'b0, 1'b0);      // end marker missing
    queue_frame(2, 8'hA5, 8'd3, CHK_WRONG, 1'b1, 1'b0);     // checksum mismatch
    queue_random_traffic(150, 1'b0);

    // equal sync bytes at the low extreme: the held sync byte starts the next frame
    queue_config(REG_SYNC_FIRST, 8'h00);
    queue_config(REG_SYNC_SECOND, 8'h00);
    queue_config(REG_END_MARKER, 8'hFF);
    queue_frame(2, 8'h3C, 8'd2, CHK_GOOD, 1'b1, 1'b0);
    queue_frame(1, 8'hC3, 8'd1, CHK_GOOD, 1'b1, 1'b0);
    queue_random_traffic(180, 1'b0);

    // everything at the high extreme
    queue_config(REG_SYNC_FIRST, 8'hFF);
    queue_config(REG_SYNC_SECOND, 8'hFF);
    queue_config(REG_END_MARKER, 8'hFF);
    queue_random_traffic(180, 1'b0);

    // random pattern, with one frame of the longest length
    queue_config(REG_SYNC_FIRST, 8'($urandom_range(0, 255)));
    queue_config(REG_SYNC_SECOND, 8'($urandom_range(0, 255)));
    queue_config(REG_END_MARKER, 8'($urandom_range(0, 255)));
    queue_random_traffic(180, 1'b1);

    // mixed extremes
    queue_config(REG_SYNC_FIRST, 8'hFF);
    queue_config(REG_SYNC_SECOND, 8'h00);
    queue_config(REG_END_MARKER, 8'h00);
    queue_random_traffic(180, 1'b0);

    // back to the reset pattern
    queue_config(REG_SYNC_FIRST, SYNC_FIRST_RST);
    queue_config(REG_SYNC_SECOND, SYNC_SECOND_RST);
    queue_config(REG_END_MARKER, END_MARKER_RST);
    queue_random_traffic(180, 1'b0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bytes and %0d register writes across six sync settings",
             bytes_in, cfg_writes);
    $display("items seen: %0d text, %0d payload, %0d ok, %0d bad checksum, %0d no end",
             kind_seen[KIND_TEXT], kind_seen[KIND_PAYLOAD], kind_seen[KIND_OK],
             kind_seen[KIND_MISMATCH], kind_seen[KIND_NO_END]);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/fpd_pkg.sv
hw/rtl/fpd_cfg_regs.sv
hw/rtl/fpd_step.sv
hw/rtl/framed_packet_decoder_core.sv
sim/tb_top.sv
